/* src/mic_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mic_pkg: shared types and constants of the integer core
// Opcodes, bus request codes, state encoding and coprocessor write masks.
// ---------------------------------------------------------------------------
package mic_pkg;

  localparam int XLEN = 32;

  localparam logic [31:0] RESET_PC   = 32'hBFC00000;
  localparam logic [31:0] SEG_MASK   = 32'hF0000000;
  localparam logic [31:0] LWL_KEEP   = 32'h00FFFFFF;
  localparam logic [31:0] LWR_KEEP   = 32'hFFFFFF00;
  localparam logic [31:0] WORD_ALIGN = 32'hFFFFFFFC;

  // request kinds
  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  // access sizes
  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  // fault codes
  localparam logic [2:0] FLT_NONE = 3'd0;
  localparam logic [2:0] FLT_OVF  = 3'd1;
  localparam logic [2:0] FLT_ADDR = 3'd2;
  localparam logic [2:0] FLT_BRK  = 3'd3;
  localparam logic [2:0] FLT_SYS  = 3'd4;

  // pending access codes
  localparam logic [3:0] ACC_NONE = 4'd0;
  localparam logic [3:0] ACC_LB   = 4'd1;
  localparam logic [3:0] ACC_LBU  = 4'd2;
  localparam logic [3:0] ACC_LH   = 4'd3;
  localparam logic [3:0] ACC_LHU  = 4'd4;
  localparam logic [3:0] ACC_LW   = 4'd5;
  localparam logic [3:0] ACC_LWL  = 4'd6;
  localparam logic [3:0] ACC_LWR  = 4'd7;
  localparam logic [3:0] ACC_SWL  = 4'd8;
  localparam logic [3:0] ACC_SWR  = 4'd9;

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_COP0    = 6'h10;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LWL     = 6'h22;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_LWR     = 6'h26;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SWL     = 6'h2A;
  localparam logic [5:0] OP_SW      = 6'h2B;
  localparam logic [5:0] OP_SWR     = 6'h2E;

  // special function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_SYS   = 6'h0C;
  localparam logic [5:0] FN_BRK   = 6'h0D;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  localparam logic [4:0] COP_MF = 5'd0;
  localparam logic [4:0] COP_MT = 5'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_OUT0, ST_OUT1
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  size;
    logic [2:0]  fault;
    logic        last;
  } req_t;

  // writable bits of each coprocessor register
  function automatic logic [31:0] cop0_wmask(input logic [3:0] idx);
    logic [31:0] m;
    case (idx)
      4'd3, 4'd5, 4'd9, 4'd11, 4'd12: m = 32'hFFFFFFFF;
      4'd7:    m = 32'hFFC0F03F;
      4'd13:   m = 32'h00000300;
      default: m = 32'h00000000;
    endcase
    return m;
  endfunction

endpackage

/* src/mic_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mic_div: unsigned restoring divider
// One quotient bit per cycle; a zero divisor gives all ones and the dividend.
// ---------------------------------------------------------------------------
module mic_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mic_pkg::XLEN-1:0]  dividend,
  input  logic [mic_pkg::XLEN-1:0]  divisor,
  output logic                      done,
  output logic [mic_pkg::XLEN-1:0]  quotient,
  output logic [mic_pkg::XLEN-1:0]  remainder
);
  import mic_pkg::*;

  localparam int CW = $clog2(XLEN + 1);

  logic [XLEN-1:0] rem, quo, dvs;
  logic [CW-1:0]   cnt;
  logic [XLEN:0]   trial, diff;

  assign trial = {rem, quo[XLEN-1]};
  assign diff  = trial - {1'b0, dvs};

  // step one bit per cycle until the count runs out
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(XLEN);
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) done <= 1'b1;
        if (!diff[XLEN]) begin
          rem <= diff[XLEN-1:0];
          quo <= {quo[XLEN-2:0], 1'b1};
        end else begin
          rem <= trial[XLEN-1:0];
          quo <= {quo[XLEN-2:0], 1'b0};
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* src/mips_integer_core_delay_slots_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mips_integer_core_delay_slots_core: R3000A integer core on a request stream
// Takes fetched words and load data, issues fetch, read and write requests.
// ---------------------------------------------------------------------------
// An instruction is accepted (register file read) and executed, then its
// requests are delivered, one output state each (two requests for stores and
// swl/swr returns), each held until m_tready. The register file is a
// synchronous two-read, one-write memory, and the execute state uses its registered read data.
// Multiplies pass through a state for the product sign fix; divides wait in
// a state on the bit-serial divider. A new request is taken only after all
// requests of the previous one are delivered. There is no clearing pass:
// per-entry valid bits make the register file read as zero after reset.
module mips_integer_core_delay_slots_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // word
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // request_address, write_data, access_size, fault
  output logic [1:0]  m_tuser,   // request_kind
  output logic        m_tlast    // last
);
  import mic_pkg::*;

  state_t state, state_next;

  // architectural state
  logic [31:0] reset_vector, pc, hi, lo, bt;
  logic        bp, armed, started;
  logic [4:0]  lq_dest [2];
  logic [31:0] lq_val  [2];
  logic [1:0]  lq_v;
  logic [31:0] cop [16];
  logic [3:0]  pending;
  logic [31:0] held_addr;
  logic [4:0]  held_rt;

  // register file
  logic [31:0] gpr [32];
  logic [31:0] gv;
  logic        g_we;
  logic [4:0]  g_wa, g_ra, g_rb;
  logic [31:0] g_wd, g_qa, g_qb;
  logic        va_ok, vb_ok, fa, fb;
  logic [31:0] fwd_d;
  logic [31:0] vs, vt;

  // held request
  logic [31:0] ins;
  logic        is_data;
  logic        s_acc;

  // outputs
  req_t res0, res1, res_cur;
  logic two_res;

  // mult and div
  logic [63:0] prod;
  logic        mneg, dsgn, dneg_q, dneg_r;
  logic        div_start, div_done;
  logic [31:0] div_q, div_r, ma, mb;

  assign s_acc = s_tvalid && s_tready;

  assign g_ra = s_tdata[25:21];
  assign g_rb = s_tuser ? held_rt : s_tdata[20:16];

  // ---------------- decode and execute ----------------
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] imm, simm, ea, bra, sum, dif, addi_r;
  logic        x_we, x_take, x_store, x_cop_we, x_hi_we, x_lo_we, x_mul, x_div, x_sgn;
  logic [4:0]  x_wa;
  logic [31:0] x_wd, x_target, x_sdata;
  logic [2:0]  x_fault, x_mfault;
  logic [3:0]  x_code;
  logic [1:0]  x_size;
  logic        bp1, bp_n, armed_n;
  logic [31:0] bt1, pc_n;
  // data return
  logic [4:0]  sh, shr;
  logic [31:0] cur, nw, lv;

  always_comb begin
    op   = ins[31:26];
    rs   = ins[25:21];
    rt   = ins[20:16];
    rd   = ins[15:11];
    sa   = ins[10:6];
    fn   = ins[5:0];
    imm  = {16'd0, ins[15:0]};
    simm = {{16{ins[15]}}, ins[15:0]};
    ea   = vs + simm;
    bra  = {simm[29:0], 2'b00} + pc + 32'd4;
    sum  = vs + vt;
    dif  = vs - vt;
    addi_r = vs + simm;

    x_we = 1'b0; x_wa = rd; x_wd = '0;
    x_take = 1'b0; x_target = vs;
    x_fault = FLT_NONE; x_mfault = FLT_NONE;
    x_code = ACC_NONE; x_size = SZ_WORD;
    x_store = 1'b0; x_sdata = '0;
    x_cop_we = 1'b0; x_hi_we = 1'b0; x_lo_we = 1'b0;
    x_mul = 1'b0; x_div = 1'b0; x_sgn = 1'b0;

    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_ADD: begin
            if (((vs ^ sum) & (vt ^ sum) & 32'h80000000) != '0) x_fault = FLT_OVF;
            else begin x_we = 1'b1; x_wd = sum; end
          end
          FN_ADDU: begin x_we = 1'b1; x_wd = sum; end
          FN_SUB: begin
            if (((vs ^ vt) & (vs ^ dif) & 32'h80000000) != '0) x_fault = FLT_OVF;
            else begin x_we = 1'b1; x_wd = dif; end
          end
          FN_SUBU: begin x_we = 1'b1; x_wd = dif; end
          FN_AND:  begin x_we = 1'b1; x_wd = vs & vt; end
          FN_OR:   begin x_we = 1'b1; x_wd = vs | vt; end
          FN_XOR:  begin x_we = 1'b1; x_wd = vs ^ vt; end
          FN_NOR:  begin x_we = 1'b1; x_wd = ~(vs | vt); end
          FN_SLT:  begin x_we = 1'b1; x_wd = {31'd0, $signed(vs) < $signed(vt)}; end
          FN_SLTU: begin x_we = 1'b1; x_wd = {31'd0, vs < vt}; end
          FN_SLL:  begin x_we = 1'b1; x_wd = vt << sa; end
          FN_SRL:  begin x_we = 1'b1; x_wd = vt >> sa; end
          FN_SRA:  begin x_we = 1'b1; x_wd = 32'($signed(vt) >>> sa); end
          FN_SLLV: begin x_we = 1'b1; x_wd = vt << vs[4:0]; end
          FN_SRLV: begin x_we = 1'b1; x_wd = vt >> vs[4:0]; end
          FN_SRAV: begin x_we = 1'b1; x_wd = 32'($signed(vt) >>> vs[4:0]); end
          FN_JR: begin
            if (vs[1:0] != 2'b00) x_fault = FLT_ADDR;
            x_take = 1'b1;
          end
          FN_JALR: begin
            if (vs[1:0] != 2'b00) x_fault = FLT_ADDR;
            x_take = 1'b1; x_we = 1'b1; x_wd = pc + 32'd8;
          end
          FN_SYS:  x_fault = FLT_SYS;
          FN_BRK:  x_fault = FLT_BRK;
          FN_MFHI: begin x_we = 1'b1; x_wd = hi; end
          FN_MTHI: x_hi_we = 1'b1;
          FN_MFLO: begin x_we = 1'b1; x_wd = lo; end
          FN_MTLO: x_lo_we = 1'b1;
          FN_MULT:  begin x_mul = 1'b1; x_sgn = 1'b1; end
          FN_MULTU: x_mul = 1'b1;
          FN_DIV:   begin x_div = 1'b1; x_sgn = 1'b1; end
          FN_DIVU:  x_div = 1'b1;
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt[3:1] == 3'b000) begin
          if (rt[4]) begin x_we = 1'b1; x_wa = 5'd31; x_wd = pc + 32'd8; end
          x_take = rt[0] ? !vs[31] : vs[31];
          x_target = bra;
        end
      end
      OP_J: begin
        x_take = 1'b1;
        x_target = {ins[25:0], 2'b00} | ((pc + 32'd4) & SEG_MASK);
      end
      OP_JAL: begin
        x_take = 1'b1;
        x_target = {ins[25:0], 2'b00} | ((pc + 32'd4) & SEG_MASK);
        x_we = 1'b1; x_wa = 5'd31; x_wd = pc + 32'd8;
      end
      OP_BEQ:  begin x_take = (vs == vt); x_target = bra; end
      OP_BNE:  begin x_take = (vs != vt); x_target = bra; end
      OP_BLEZ: begin x_take = vs[31] || (vs == '0); x_target = bra; end
      OP_BGTZ: begin x_take = !vs[31] && (vs != '0); x_target = bra; end
      OP_ADDI: begin
        x_wa = rt;
        if (((vs ^ addi_r) & (simm ^ addi_r) & 32'h80000000) != '0) x_fault = FLT_OVF;
        else begin x_we = 1'b1; x_wd = addi_r; end
      end
      OP_ADDIU: begin x_we = 1'b1; x_wa = rt; x_wd = addi_r; end
      OP_SLTI:  begin x_we = 1'b1; x_wa = rt; x_wd = {31'd0, $signed(vs) < $signed(simm)}; end
      OP_SLTIU: begin x_we = 1'b1; x_wa = rt; x_wd = {31'd0, vs < simm}; end
      OP_ANDI:  begin x_we = 1'b1; x_wa = rt; x_wd = vs & imm; end
      OP_ORI:   begin x_we = 1'b1; x_wa = rt; x_wd = vs | imm; end
      OP_XORI:  begin x_we = 1'b1; x_wa = rt; x_wd = vs ^ imm; end
      OP_LUI:   begin x_we = 1'b1; x_wa = rt; x_wd = {ins[15:0], 16'd0}; end
      OP_COP0: begin
        if (rs == COP_MF) begin
          x_we = 1'b1; x_wa = rt; x_wd = rd[4] ? 32'd0 : cop[rd[3:0]];
        end else if (rs == COP_MT && !rd[4]) begin
          x_cop_we = 1'b1;
        end
      end
      OP_LB:  begin x_code = ACC_LB;  x_size = SZ_BYTE; end
      OP_LBU: begin x_code = ACC_LBU; x_size = SZ_BYTE; end
      OP_LH: begin
        x_code = ACC_LH; x_size = SZ_HALF;
        if (ea[0]) x_mfault = FLT_ADDR;
      end
      OP_LHU: begin
        x_code = ACC_LHU; x_size = SZ_HALF;
        if (ea[0]) x_mfault = FLT_ADDR;
      end
      OP_LW: begin
        x_code = ACC_LW;
        if (ea[1:0] != 2'b00) x_mfault = FLT_ADDR;
      end
      OP_LWL: x_code = ACC_LWL;
      OP_LWR: x_code = ACC_LWR;
      OP_SWL: x_code = ACC_SWL;
      OP_SWR: x_code = ACC_SWR;
      OP_SB: begin x_store = 1'b1; x_size = SZ_BYTE; x_sdata = {24'd0, vt[7:0]}; end
      OP_SH: begin
        x_store = 1'b1; x_size = SZ_HALF; x_sdata = {16'd0, vt[15:0]};
        if (ea[0]) x_mfault = FLT_ADDR;
      end
      OP_SW: begin
        x_store = 1'b1; x_sdata = vt;
        if (ea[1:0] != 2'b00) x_mfault = FLT_ADDR;
      end
      default: ;
    endcase

    // take the branch, then step the pc through the delay slot
    bp1 = bp || x_take;
    bt1 = x_take ? x_target : bt;
    pc_n = pc + 32'd4;
    bp_n = bp1;
    armed_n = armed;
    if (bp1) begin
      if (armed) armed_n = 1'b0;
      else begin
        bp_n = 1'b0;
        pc_n = bt1;
        armed_n = 1'b1;
      end
    end

    // merge returned data
    sh  = {held_addr[1:0], 3'b000};
    shr = 5'd24 - sh;
    cur = (held_rt != 5'd0 && lq_v[1] && lq_dest[1] == held_rt) ? lq_val[1] : vt;
    if (pending == ACC_SWL)
      nw = (ins & (LWR_KEEP << sh)) | (vt >> shr);
    else
      nw = (ins & (LWL_KEEP >> shr)) | (vt << sh);
    case (pending)
      ACC_LB:  lv = {{24{ins[7]}}, ins[7:0]};
      ACC_LBU: lv = {24'd0, ins[7:0]};
      ACC_LH:  lv = {{16{ins[15]}}, ins[15:0]};
      ACC_LHU: lv = {16'd0, ins[15:0]};
      ACC_LW:  lv = ins;
      ACC_LWL: lv = (ins << shr) | (cur & (LWL_KEEP >> sh));
      default: lv = (ins >> sh) | (cur & (LWR_KEEP << shr));
    endcase

    ma = (x_sgn && vs[31]) ? 32'd0 - vs : vs;
    mb = (x_sgn && vt[31]) ? 32'd0 - vt : vt;
  end

  assign div_start = (state == ST_EXEC) && !is_data && x_div;

  mic_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (ma),
    .divisor   (mb),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // ---------------- register file write selection ----------------
  always_comb begin
    g_we = 1'b0; g_wa = lq_dest[1]; g_wd = lq_val[1];
    if (state == ST_IDLE) begin
      g_we = s_acc && !s_tuser && pending == ACC_NONE && lq_v[1];
    end else if (state == ST_EXEC && !is_data) begin
      g_we = x_we; g_wa = x_wa; g_wd = x_wd;
    end
    if (g_wa == 5'd0) g_we = 1'b0;
  end

  // write, read two ports, sample forwarding
  always_ff @(posedge clk) begin
    if (g_we) gpr[g_wa] <= g_wd;
    g_qa  <= gpr[g_ra];
    g_qb  <= gpr[g_rb];
    va_ok <= gv[g_ra];
    vb_ok <= gv[g_rb];
    fa    <= g_we && g_wa == g_ra;
    fb    <= g_we && g_wa == g_rb;
    fwd_d <= g_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) gv <= '0;
    else if (g_we) gv[g_wa] <= 1'b1;
  end

  assign vs = fa ? fwd_d : (va_ok ? g_qa : 32'd0);
  assign vt = fb ? fwd_d : (vb_ok ? g_qb : 32'd0);

  // ---------------- state register and next state ----------------
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_acc && (s_tuser == (pending != ACC_NONE))) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!is_data && x_mul)      state_next = ST_MUL;
        else if (!is_data && x_div) state_next = ST_DIV;
        else                        state_next = ST_OUT0;
      end
      ST_MUL: state_next = ST_OUT0;
      ST_DIV: if (div_done) state_next = ST_OUT0;
      ST_OUT0: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = two_res ? ST_OUT1 : ST_IDLE;
      end
      ST_OUT1: begin
        m_tvalid = 1'b1;
        if (m_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_vector <= RESET_PC;
      pc       <= RESET_PC;
      hi       <= '0;
      lo       <= '0;
      bp       <= 1'b0;
      bt       <= '0;
      armed    <= 1'b1;
      started  <= 1'b0;
      lq_v     <= '0;
      lq_dest[0] <= '0; lq_dest[1] <= '0;
      lq_val[0]  <= '0; lq_val[1]  <= '0;
      pending  <= ACC_NONE;
      held_addr <= '0;
      held_rt  <= '0;
      for (int i = 0; i < 16; i++) cop[i] <= '0;
    end else begin
      if (cfg_we) begin
        reset_vector <= cfg_wdata;
        if (!started) pc <= cfg_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (s_acc) begin
            ins <= s_tdata;
            is_data <= s_tuser;
            // shift the load delay queue at the start of an instruction
            if (!s_tuser && pending == ACC_NONE) begin
              started <= 1'b1;
              if (lq_v[0]) begin
                lq_dest[1] <= lq_dest[0];
                lq_val[1]  <= lq_val[0];
                lq_v       <= 2'b10;
              end else begin
                lq_v[1] <= 1'b0;
              end
            end
          end
        end
        ST_EXEC: begin
          if (is_data) begin
            pending <= ACC_NONE;
            if (pending == ACC_SWL || pending == ACC_SWR) begin
              res0 <= '{KIND_WRITE, held_addr & WORD_ALIGN, nw, SZ_WORD, FLT_NONE, 1'b0};
              res1 <= '{KIND_FETCH, pc, 32'd0, SZ_WORD, FLT_NONE, 1'b1};
              two_res <= 1'b1;
            end else begin
              if (lq_v[1] && lq_dest[1] == held_rt) lq_v[1] <= 1'b0;
              lq_dest[0] <= held_rt;
              lq_val[0]  <= lv;
              lq_v[0]    <= 1'b1;
              res0 <= '{KIND_FETCH, pc, 32'd0, SZ_WORD, FLT_NONE, 1'b1};
              two_res <= 1'b0;
            end
          end else begin
            pc    <= pc_n;
            bp    <= bp_n;
            bt    <= bt1;
            armed <= armed_n;
            if (x_hi_we) hi <= vs;
            if (x_lo_we) lo <= vs;
            if (x_cop_we) cop[rd[3:0]] <= vt & cop0_wmask(rd[3:0]);
            prod <= ma * mb;
            mneg <= x_sgn && (vs[31] ^ vt[31]);
            dsgn <= x_sgn;
            dneg_q <= x_sgn && (vs[31] ^ vt[31]);
            dneg_r <= x_sgn && vs[31];
            if (x_code != ACC_NONE) begin
              pending   <= x_code;
              held_addr <= ea;
              held_rt   <= rt;
              res0 <= '{KIND_READ, (x_code >= ACC_LWL) ? (ea & WORD_ALIGN) : ea, 32'd0,
                        x_size, x_mfault, 1'b1};
              two_res <= 1'b0;
            end else if (x_store) begin
              res0 <= '{KIND_WRITE, ea, x_sdata, x_size, x_mfault, 1'b0};
              res1 <= '{KIND_FETCH, pc_n, 32'd0, SZ_WORD, FLT_NONE, 1'b1};
              two_res <= 1'b1;
            end else begin
              res0 <= '{KIND_FETCH, pc_n, 32'd0, SZ_WORD, x_fault, 1'b1};
              two_res <= 1'b0;
            end
          end
        end
        ST_MUL: begin
          {hi, lo} <= mneg ? 64'd0 - prod : prod;
        end
        ST_DIV: begin
          if (div_done) begin
            lo <= dneg_q ? 32'd0 - div_q : div_q;
            hi <= dneg_r ? 32'd0 - div_r : div_r;
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------- output ----------------
  assign res_cur = (state == ST_OUT1) ? res1 : res0;
  assign m_tdata = {3'd0, res_cur.fault, res_cur.size, res_cur.data, res_cur.addr};
  assign m_tuser = res_cur.kind;
  assign m_tlast = res_cur.last;

`ifndef SYNTHESIS
  // a request is never taken while a result is offered
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input accepted while output pending");
  // fetches and reads end the requests of an item
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == KIND_FETCH || m_tuser == KIND_READ)) |-> m_tlast)
    else $error("fetch or read not marked last");
  // divider finishes only while waiting for it
  assert property (@(posedge clk) disable iff (rst) div_done |-> (state == ST_DIV))
    else $error("divider done outside divide wait");
  // sign flag of a divide is unused by unsigned ops
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !dsgn) |-> (!dneg_q && !dneg_r))
    else $error("unsigned divide with sign fix");
`endif

endmodule

/* bench/mips_integer_core_delay_slots_core_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mips_integer_core_delay_slots_core_test: self-checking bench of the core
// Streams instruction words and load data into the core and predicts every
// bus request: fetch, read and write, with its address, data, size and fault.
// ---------------------------------------------------------------------------
import mic_pkg::*;

class core_scoreboard;
  bit [31:0] gpr[32];
  bit [31:0] hi, lo, pc, br_target, rst_vec;
  bit        br_pending, slot_armed, started;
  bit [4:0]  lq_dest[2];
  bit [31:0] lq_val[2];
  bit        lq_v[2];
  bit [31:0] cop[16];
  logic [3:0] pend_acc;
  bit [31:0] held_addr;
  bit [4:0]  held_rt;
  req_t      expected_reqs[$];
  int        mismatches;

  function void clear();
    foreach (gpr[i]) gpr[i] = '0;
    foreach (cop[i]) cop[i] = '0;
    hi = '0; lo = '0; rst_vec = RESET_PC; pc = RESET_PC;
    br_pending = 0; br_target = '0; slot_armed = 1; started = 0;
    for (int i = 0; i < 2; i++) begin
      lq_dest[i] = '0; lq_val[i] = '0; lq_v[i] = 0;
    end
    pend_acc = ACC_NONE; held_addr = '0; held_rt = '0;
    expected_reqs.delete();
    mismatches = 0;
  endfunction

  function void write_vector(bit [31:0] v);
    rst_vec = v;
    if (!started) pc = v;
  endfunction

  function bit [31:0] cop_mask(bit [3:0] idx);
    case (idx)
      4'd3, 4'd5, 4'd9, 4'd11, 4'd12: return 32'hFFFFFFFF;
      4'd7: return 32'hFFC0F03F;
      4'd13: return 32'h00000300;
      default: return 32'h0;
    endcase
  endfunction

  function void set_reg(bit [4:0] i, bit [31:0] v);
    if (i != 0) gpr[i] = v;
  endfunction

  function void queue_req(logic [1:0] k, bit [31:0] a, bit [31:0] d, logic [1:0] s,
                          logic [2:0] f, bit l);
    req_t r;
    r.kind = k; r.addr = a; r.data = d; r.size = s; r.fault = f; r.last = l;
    expected_reqs.push_back(r);
  endfunction

  function void do_div(bit [31:0] a, bit [31:0] b, bit sgn);
    if (b == 0) begin
      lo = (sgn && a[31]) ? 32'd1 : 32'hFFFFFFFF;
      hi = a;
    end else if (!sgn) begin
      lo = a / b; hi = a % b;
    end else if (a == 32'h80000000 && b == 32'hFFFFFFFF) begin
      lo = 32'h80000000; hi = 0;
    end else begin
      lo = $signed(a) / $signed(b);
      hi = $signed(a) % $signed(b);
    end
  endfunction

  // finish a pending read: merge and queue the load, or emit the swl/swr write
  function int data_return(bit [31:0] data);
    logic [3:0] code;
    bit [4:0]   rt;
    int         sh;
    bit [31:0]  cur, v, nw;
    code = pend_acc; rt = held_rt; sh = held_addr[1:0] * 8;
    cur = gpr[rt];
    pend_acc = ACC_NONE;
    if (rt != 0 && lq_v[1] && lq_dest[1] == rt) cur = lq_val[1];
    if (code == ACC_SWL || code == ACC_SWR) begin
      nw = (code == ACC_SWL) ? ((data & (LWR_KEEP << sh)) | (gpr[rt] >> (24 - sh)))
                             : ((data & (LWL_KEEP >> (24 - sh))) | (gpr[rt] << sh));
      queue_req(KIND_WRITE, held_addr & WORD_ALIGN, nw, SZ_WORD, FLT_NONE, 0);
      queue_req(KIND_FETCH, pc, 0, SZ_WORD, FLT_NONE, 1);
      return 2;
    end
    case (code)
      ACC_LB:  v = {{24{data[7]}}, data[7:0]};
      ACC_LBU: v = {24'h0, data[7:0]};
      ACC_LH:  v = {{16{data[15]}}, data[15:0]};
      ACC_LHU: v = {16'h0, data[15:0]};
      ACC_LW:  v = data;
      ACC_LWL: v = (data << (24 - sh)) | (cur & (LWL_KEEP >> sh));
      default: v = (data >> sh) | (cur & (LWR_KEEP << (24 - sh)));
    endcase
    if (lq_v[1] && lq_dest[1] == rt) lq_v[1] = 0;
    lq_dest[0] = rt; lq_val[0] = v; lq_v[0] = 1;
    queue_req(KIND_FETCH, pc, 0, SZ_WORD, FLT_NONE, 1);
    return 1;
  endfunction

  // note one accepted request; returns how many bus requests it causes
  function int note_input(bit func, bit [31:0] ins);
    bit [5:0]  op, fn;
    bit [4:0]  rs, rt, rd, sa;
    bit [31:0] imm, simm, vs, vt, cpc, r, ea, bra, sdata;
    bit [63:0] prod;
    logic [2:0] flt, mflt;
    logic [3:0] code;
    logic [1:0] size;
    bit        store, neg, take;
    if (func) begin
      if (pend_acc == ACC_NONE) return 0;
      return data_return(ins);
    end
    if (pend_acc != ACC_NONE) return 0;
    started = 1;
    // retire the load delay queue
    if (lq_v[1]) begin
      set_reg(lq_dest[1], lq_val[1]); lq_v[1] = 0;
    end
    if (lq_v[0]) begin
      lq_dest[1] = lq_dest[0]; lq_val[1] = lq_val[0]; lq_v[1] = 1; lq_v[0] = 0;
    end
    op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
    sa = ins[10:6]; fn = ins[5:0];
    imm = {16'h0, ins[15:0]}; simm = {{16{ins[15]}}, ins[15:0]};
    vs = gpr[rs]; vt = gpr[rt]; cpc = pc; ea = vs + simm;
    bra = (simm << 2) + cpc + 4;
    flt = FLT_NONE; mflt = FLT_NONE; code = ACC_NONE; size = SZ_WORD;
    store = 0; sdata = 0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_ADD: begin
            r = vs + vt;
            if (((vs ^ r) & (vt ^ r)) >> 31) flt = FLT_OVF; else set_reg(rd, r);
          end
          FN_ADDU: set_reg(rd, vs + vt);
          FN_SUB: begin
            r = vs - vt;
            if (((vs ^ vt) & (vs ^ r)) >> 31) flt = FLT_OVF; else set_reg(rd, r);
          end
          FN_SUBU: set_reg(rd, vs - vt);
          FN_AND:  set_reg(rd, vs & vt);
          FN_OR:   set_reg(rd, vs | vt);
          FN_XOR:  set_reg(rd, vs ^ vt);
          FN_NOR:  set_reg(rd, ~(vs | vt));
          FN_SLT:  set_reg(rd, ($signed(vs) < $signed(vt)) ? 1 : 0);
          FN_SLTU: set_reg(rd, (vs < vt) ? 1 : 0);
          FN_SLL:  set_reg(rd, vt << sa);
          FN_SRL:  set_reg(rd, vt >> sa);
          FN_SRA:  set_reg(rd, $signed(vt) >>> sa);
          FN_SLLV: set_reg(rd, vt << vs[4:0]);
          FN_SRLV: set_reg(rd, vt >> vs[4:0]);
          FN_SRAV: set_reg(rd, $signed(vt) >>> vs[4:0]);
          FN_JR: begin
            if (vs[1:0] != 0) flt = FLT_ADDR;
            br_target = vs; br_pending = 1;
          end
          FN_JALR: begin
            if (vs[1:0] != 0) flt = FLT_ADDR;
            br_target = vs; br_pending = 1; set_reg(rd, cpc + 8);
          end
          FN_SYS:  flt = FLT_SYS;
          FN_BRK:  flt = FLT_BRK;
          FN_MFHI: set_reg(rd, hi);
          FN_MTHI: hi = vs;
          FN_MFLO: set_reg(rd, lo);
          FN_MTLO: lo = vs;
          FN_MULT: begin
            prod = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
            lo = prod[31:0]; hi = prod[63:32];
          end
          FN_MULTU: begin
            prod = {32'h0, vs} * {32'h0, vt};
            lo = prod[31:0]; hi = prod[63:32];
          end
          FN_DIV:  do_div(vs, vt, 1);
          FN_DIVU: do_div(vs, vt, 0);
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt == 5'h00 || rt == 5'h10 || rt == 5'h01 || rt == 5'h11) begin
          neg = vs[31];
          take = rt[0] ? !neg : neg;
          if (rt[4]) set_reg(5'd31, cpc + 8);
          if (take) begin br_target = bra; br_pending = 1; end
        end
      end
      OP_J, OP_JAL: begin
        br_target = {ins[25:0], 2'b00} | ((cpc + 4) & SEG_MASK); br_pending = 1;
        if (op == OP_JAL) set_reg(5'd31, cpc + 8);
      end
      OP_BEQ:  if (vs == vt) begin br_target = bra; br_pending = 1; end
      OP_BNE:  if (vs != vt) begin br_target = bra; br_pending = 1; end
      OP_BLEZ: if (vs[31] || vs == 0) begin br_target = bra; br_pending = 1; end
      OP_BGTZ: if (!vs[31] && vs != 0) begin br_target = bra; br_pending = 1; end
      OP_ADDI: begin
        r = vs + simm;
        if (((vs ^ r) & (simm ^ r)) >> 31) flt = FLT_OVF; else set_reg(rt, r);
      end
      OP_ADDIU: set_reg(rt, vs + simm);
      OP_SLTI:  set_reg(rt, ($signed(vs) < $signed(simm)) ? 1 : 0);
      OP_SLTIU: set_reg(rt, (vs < simm) ? 1 : 0);
      OP_ANDI:  set_reg(rt, vs & imm);
      OP_ORI:   set_reg(rt, vs | imm);
      OP_XORI:  set_reg(rt, vs ^ imm);
      OP_LUI:   set_reg(rt, imm << 16);
      OP_COP0: begin
        if (rs == COP_MF) set_reg(rt, (rd < 16) ? cop[rd[3:0]] : 0);
        else if (rs == COP_MT && rd < 16) cop[rd[3:0]] = vt & cop_mask(rd[3:0]);
      end
      OP_LB:  begin code = ACC_LB; size = SZ_BYTE; end
      OP_LBU: begin code = ACC_LBU; size = SZ_BYTE; end
      OP_LH:  begin code = ACC_LH; size = SZ_HALF; if (ea[0]) mflt = FLT_ADDR; end
      OP_LHU: begin code = ACC_LHU; size = SZ_HALF; if (ea[0]) mflt = FLT_ADDR; end
      OP_LW:  begin code = ACC_LW; if (ea[1:0] != 0) mflt = FLT_ADDR; end
      OP_LWL: code = ACC_LWL;
      OP_LWR: code = ACC_LWR;
      OP_SWL: code = ACC_SWL;
      OP_SWR: code = ACC_SWR;
      OP_SB:  begin store = 1; size = SZ_BYTE; sdata = vt & 32'hFF; end
      OP_SH: begin
        store = 1; size = SZ_HALF; sdata = vt & 32'hFFFF;
        if (ea[0]) mflt = FLT_ADDR;
      end
      OP_SW:  begin store = 1; sdata = vt; if (ea[1:0] != 0) mflt = FLT_ADDR; end
      default: ;
    endcase
    // step the pc through the branch delay slot
    pc = pc + 4;
    if (br_pending) begin
      if (slot_armed) slot_armed = 0;
      else begin
        br_pending = 0; pc = br_target; slot_armed = 1;
      end
    end
    if (code != ACC_NONE) begin
      pend_acc = code; held_addr = ea; held_rt = rt;
      queue_req(KIND_READ, (code >= ACC_LWL) ? (ea & WORD_ALIGN) : ea, 0, size, mflt, 1);
      return 1;
    end
    if (store) begin
      queue_req(KIND_WRITE, ea, sdata, size, mflt, 0);
      queue_req(KIND_FETCH, pc, 0, SZ_WORD, FLT_NONE, 1);
      return 2;
    end
    queue_req(KIND_FETCH, pc, 0, SZ_WORD, flt, 1);
    return 1;
  endfunction

  // compare one delivered bus request with the oldest prediction
  function void check_result(req_t got);
    req_t exp_r;
    if (expected_reqs.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected request: kind %0d addr %h data %h", got.kind, got.addr, got.data);
      return;
    end
    exp_r = expected_reqs.pop_front();
    if (got !== exp_r) begin
      mismatches++;
      if (mismatches <= 10)
        $display("request mismatch: exp kind %0d addr %h data %h size %0d fault %0d last %0d,",
                 exp_r.kind, exp_r.addr, exp_r.data, exp_r.size, exp_r.fault, exp_r.last,
                 " got kind %0d addr %h data %h size %0d fault %0d last %0d",
                 got.kind, got.addr, got.data, got.size, got.fault, got.last);
    end
  endfunction
endclass

module mips_integer_core_delay_slots_core_test;
  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = 0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  core_scoreboard sb;
  bit  no_idle = 0;
  int  hold_off = 0;
  int  quiet_cycles = 0;
  int  useful_reqs = 0;
  int  leftover;

  mips_integer_core_delay_slots_core i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // receiver: random stalls, one long hold-off on request
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else begin
      m_tready <= no_idle || ($urandom_range(0, 99) >= 37);
    end
  end

  // check every delivered request
  always @(posedge clk) begin
    req_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = m_tuser; got.addr = m_tdata[31:0]; got.data = m_tdata[63:32];
      got.size = m_tdata[65:64]; got.fault = m_tdata[68:66]; got.last = m_tlast;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_req(input bit func, input bit [31:0] w);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 37) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1; s_tuser = func; s_tdata = w;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    if (sb.note_input(func, w) > 0) useful_reqs++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  // run one instruction and answer its read if it makes one
  task automatic run_insn(input bit [31:0] w);
    push_req(0, w);
    if (sb.pend_acc != ACC_NONE) push_req(1, $urandom());
  endtask

  task automatic write_vector(input bit [31:0] v);
    @(negedge clk);
    cfg_we = 1; cfg_wdata = v;
    @(posedge clk);
    sb.write_vector(v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic drain();
    while (sb.expected_reqs.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic bit [31:0] r_type(bit [5:0] fn, bit [4:0] rs, bit [4:0] rt,
                                       bit [4:0] rd, bit [4:0] sa);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic bit [31:0] i_type(bit [5:0] op, bit [4:0] rs, bit [4:0] rt,
                                       bit [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic bit [4:0] pick_reg();
    return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
  endfunction

  // random instruction, mostly well-formed, sometimes raw noise
  function automatic bit [31:0] rand_insn();
    bit [5:0] ops[] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL,
                        OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
                        OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_COP0, OP_LB, OP_LH,
                        OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR, OP_SB, OP_SH, OP_SWL,
                        OP_SW, OP_SWR};
    bit [5:0] fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
                        FN_JALR, FN_SYS, FN_BRK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO,
                        FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB,
                        FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    bit [5:0]  op;
    bit [31:0] w;
    if ($urandom_range(0, 99) < 5) return $urandom();
    op = ops[$urandom_range(0, ops.size() - 1)];
    w = $urandom();
    w[31:26] = op;
    w[25:21] = pick_reg();
    w[20:16] = pick_reg();
    if (op == OP_SPECIAL) begin
      w[15:11] = pick_reg();
      w[5:0] = fns[$urandom_range(0, fns.size() - 1)];
    end else if (op == OP_COP0) begin
      w[25:21] = ($urandom_range(0, 1) != 0) ? COP_MT : COP_MF;
    end else if (op == OP_REGIMM && $urandom_range(0, 3) != 0) begin
      w[20:16] = {$urandom_range(0, 1) != 0, 3'b000, $urandom_range(0, 1) != 0};
    end
    return w;
  endfunction

  initial begin
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset vector before the first instruction: extremes, then the usual value
    write_vector(32'hFFFFFFFF);
    write_vector(32'h00000000);
    write_vector(RESET_PC);

    // directed: extremes, overflow, divide corners, faults, load delay, cop0
    push_req(1, 32'hFFFFFFFF);
    run_insn(i_type(OP_LUI, 0, 1, 16'h8000));
    run_insn(i_type(OP_LUI, 0, 2, 16'h7FFF));
    run_insn(i_type(OP_ORI, 2, 2, 16'hFFFF));
    run_insn(i_type(OP_ADDIU, 0, 3, 16'hFFFF));
    run_insn(r_type(FN_ADD, 2, 2, 4, 0));
    run_insn(i_type(OP_ADDI, 2, 4, 16'h0001));
    run_insn(r_type(FN_SUB, 1, 2, 4, 0));
    run_insn(r_type(FN_DIV, 1, 3, 0, 0));
    run_insn(r_type(FN_DIV, 1, 0, 0, 0));
    run_insn(r_type(FN_DIVU, 2, 0, 0, 0));
    run_insn(r_type(FN_MULT, 1, 3, 0, 0));
    run_insn(r_type(FN_MULTU, 3, 3, 0, 0));
    run_insn(r_type(FN_SRAV, 3, 1, 7, 0));
    run_insn(r_type(FN_JR, 3, 0, 0, 0));
    run_insn(r_type(FN_SRA, 0, 1, 7, 5'd31));
    run_insn(i_type(OP_LH, 0, 5, 16'h0001));
    run_insn(i_type(OP_LW, 0, 5, 16'h0002));
    run_insn(i_type(OP_LWL, 0, 5, 16'h0001));
    run_insn(i_type(OP_LWR, 0, 5, 16'h0002));
    run_insn(i_type(OP_SWL, 0, 2, 16'h0003));
    run_insn(i_type(OP_SWR, 0, 2, 16'h0001));
    run_insn(i_type(OP_SW, 0, 2, 16'h0002));
    run_insn(i_type(OP_SH, 0, 2, 16'h0001));
    run_insn(r_type(FN_BRK, 0, 0, 0, 0));
    run_insn(r_type(FN_SYS, 0, 0, 0, 0));
    run_insn({OP_COP0, COP_MT, 5'd2, 5'd7, 11'h0});
    run_insn({OP_COP0, COP_MT, 5'd2, 5'd20, 11'h0});
    run_insn({OP_COP0, COP_MF, 5'd6, 5'd7, 11'h0});
    run_insn({OP_COP0, COP_MF, 5'd6, 5'd20, 11'h0});
    run_insn(32'hFC000000);
    drain();

    // random phases with vector writes between them
    for (int phase = 0; phase < 3; phase++) begin
      while (useful_reqs < 40 + (phase + 1) * 500) begin
        no_idle = (useful_reqs % 500) >= 300 && (useful_reqs % 500) < 400;
        if (phase == 1 && useful_reqs == 800 && hold_off == 0) hold_off = 300;
        if (sb.pend_acc != ACC_NONE)
          push_req($urandom_range(0, 99) >= 4, $urandom());
        else
          push_req($urandom_range(0, 99) < 3, ($urandom_range(0, 99) < 3) ? $urandom()
                                                                          : rand_insn());
      end
      no_idle = 0;
      drain();
      case (phase)
        0: write_vector(32'hFFFFFFFF);
        1: write_vector(32'h00000000);
        default: write_vector($urandom());
      endcase
    end

    // close any open read so nothing is left hanging
    if (sb.pend_acc != ACC_NONE) push_req(1, $urandom());
    drain();
    leftover = sb.expected_reqs.size();
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
src/mic_pkg.sv
src/mic_div.sv
src/mips_integer_core_delay_slots_core.sv
bench/mips_integer_core_delay_slots_core_test.sv
